FILE: src/glms_pkg.sv
package glms_pkg;

  localparam int unsigned HEIGHT_W   = 4;
  localparam int unsigned COL_CFG_W  = 9;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned RISK_W     = 28;
  localparam int unsigned COUNT_W    = 24;

  localparam int unsigned MAX_COLUMNS_DEFAULT = 256;
  localparam int unsigned COLS_RESET          = 64;
  localparam int unsigned ROWS_RESET          = 64;
  localparam int unsigned RES_DEPTH           = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;

  localparam logic [HEIGHT_W-1:0] BORDER_HEIGHT = 4'd9;
  localparam logic [RISK_W-1:0]   RISK_LIMIT    = 28'd150994944;
  localparam logic [COUNT_W-1:0]  COUNT_LIMIT   = 24'd16776960;

  // One line cell: the same column two rows back and one row back
  typedef struct packed {
    logic [HEIGHT_W-1:0] older;
    logic [HEIGHT_W-1:0] newer;
  } glms_line_t;

  // One column of the three-row window with its position flags
  typedef struct packed {
    logic [HEIGHT_W-1:0] top;
    logic [HEIGHT_W-1:0] mid;
    logic [HEIGHT_W-1:0] bot;
    logic                has_up;
    logic                has_mid;
    logic                first;
    logic                last_col;
    logic                last_row;
  } glms_col_t;

  typedef struct packed {
    logic [RISK_W-1:0]  total_risk;
    logic [COUNT_W-1:0] minimum_count;
  } glms_res_t;

endpackage

FILE: src/glms_if.sv
interface glms_in_if import glms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface glms_out_if import glms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RISK_W-1:0]  total_risk;
  logic [COUNT_W-1:0] minimum_count;

  modport source (output valid, output total_risk, output minimum_count, input ready);
  modport sink (input valid, input total_risk, input minimum_count, output ready);
endinterface

FILE: src/glms_line_cell.sv
module glms_line_cell import glms_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = $clog2(MAX_COLUMNS_DEFAULT)
) (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [IDX_W-1:0] entry_i,
  input  glms_line_t       fresh_i,
  input  glms_line_t       prev_i,
  output glms_line_t       data_o
);

  glms_line_t data_q;
  glms_line_t data_d;

  // The entry cell takes the new column, all others take their neighbour
  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = (entry_i == IDX_W'(INDEX)) ? fresh_i : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/glms_scorer.sv
module glms_scorer import glms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      restart_i,
  input  logic      col_valid_i,
  input  glms_col_t col_i,
  output logic      push_o,
  output glms_res_t res_o,
  output logic [1:0] ends_in_flight_o
);

  glms_col_t slot_q [3];
  logic      judge_v_q;

  logic        stage_v_q;
  logic        end_q;
  logic [6:0]  inc_risk_q;
  logic [2:0]  inc_cnt_q;
  logic [6:0]  inc_risk_d;
  logic [2:0]  inc_cnt_d;
  logic        end_d;

  logic [RISK_W-1:0]  risk_q, risk_d, risk_sat;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_sat;
  logic [RISK_W:0]    risk_sum;
  logic [COUNT_W:0]   cnt_sum;

  logic hit1, hit2, hit3, hit4;

  function automatic logic is_min(input logic [HEIGHT_W-1:0] v, input logic [HEIGHT_W-1:0] up,
                                  input logic [HEIGHT_W-1:0] dn, input logic [HEIGHT_W-1:0] lf,
                                  input logic [HEIGHT_W-1:0] rt);
    return (v < up) && (v < dn) && (v < lf) && (v < rt);
  endfunction

  function automatic logic [6:0] weight(input logic hit, input logic [HEIGHT_W-1:0] v);
    return hit ? (7'(v) + 7'd1) : 7'd0;
  endfunction

  // Window columns: newest first, shifted once per accepted cell
  always_ff @(posedge clk_i) begin
    if (col_valid_i) begin
      slot_q[0] <= col_i;
      slot_q[1] <= slot_q[0];
      slot_q[2] <= slot_q[1];
    end
  end

  // Middle row, one column back: its right neighbour has just arrived
  // Middle row at the row end: right neighbour is the border
  // Bottom row of the frame: the cell one back and the cell just arrived
  always_comb begin
    hit1 = slot_q[0].has_mid && !slot_q[0].first &&
           is_min(slot_q[1].mid,
                  slot_q[1].has_up ? slot_q[1].top : BORDER_HEIGHT,
                  slot_q[1].bot,
                  slot_q[1].first ? BORDER_HEIGHT : slot_q[2].mid,
                  slot_q[0].mid);
    hit2 = slot_q[0].has_mid && slot_q[0].last_col &&
           is_min(slot_q[0].mid,
                  slot_q[0].has_up ? slot_q[0].top : BORDER_HEIGHT,
                  slot_q[0].bot,
                  slot_q[0].first ? BORDER_HEIGHT : slot_q[1].mid,
                  BORDER_HEIGHT);
    hit3 = slot_q[0].last_row && !slot_q[0].first &&
           is_min(slot_q[1].bot,
                  slot_q[1].has_mid ? slot_q[1].mid : BORDER_HEIGHT,
                  BORDER_HEIGHT,
                  slot_q[1].first ? BORDER_HEIGHT : slot_q[2].bot,
                  slot_q[0].bot);
    hit4 = slot_q[0].last_row && slot_q[0].last_col &&
           is_min(slot_q[0].bot,
                  slot_q[0].has_mid ? slot_q[0].mid : BORDER_HEIGHT,
                  BORDER_HEIGHT,
                  slot_q[0].first ? BORDER_HEIGHT : slot_q[1].bot,
                  BORDER_HEIGHT);
    inc_risk_d = weight(hit1, slot_q[1].mid) + weight(hit2, slot_q[0].mid) +
                 weight(hit3, slot_q[1].bot) + weight(hit4, slot_q[0].bot);
    inc_cnt_d  = 3'(hit1) + 3'(hit2) + 3'(hit3) + 3'(hit4);
    end_d      = slot_q[0].last_row && slot_q[0].last_col;
  end

  always_ff @(posedge clk_i) begin
    inc_risk_q <= inc_risk_d;
    inc_cnt_q  <= inc_cnt_d;
    end_q      <= end_d;
  end

  // Saturating accumulate
  always_comb begin
    risk_sum = (RISK_W+1)'(risk_q) + (RISK_W+1)'(inc_risk_q);
    cnt_sum  = (COUNT_W+1)'(cnt_q) + (COUNT_W+1)'(inc_cnt_q);
    risk_sat = (risk_sum > (RISK_W+1)'(RISK_LIMIT)) ? RISK_LIMIT : risk_sum[RISK_W-1:0];
    cnt_sat  = (cnt_sum > (COUNT_W+1)'(COUNT_LIMIT)) ? COUNT_LIMIT : cnt_sum[COUNT_W-1:0];

    risk_d = risk_q;
    cnt_d  = cnt_q;
    if (restart_i) begin
      risk_d = '0;
      cnt_d  = '0;
    end else if (stage_v_q) begin
      // Drop the sums once the frame result leaves
      risk_d = end_q ? '0 : risk_sat;
      cnt_d  = end_q ? '0 : cnt_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      judge_v_q <= 1'b0;
      stage_v_q <= 1'b0;
      risk_q    <= '0;
      cnt_q     <= '0;
    end else begin
      judge_v_q <= col_valid_i;
      stage_v_q <= judge_v_q;
      risk_q    <= risk_d;
      cnt_q     <= cnt_d;
    end
  end

  assign push_o              = stage_v_q && end_q;
  assign res_o.total_risk    = risk_sat;
  assign res_o.minimum_count = cnt_sat;
  assign ends_in_flight_o    = 2'(judge_v_q && end_d) + 2'(stage_v_q && end_q);

endmodule

FILE: src/grid_local_minimum_scorer_unit.sv
// Four-neighbour local minimum scorer.
// Input channel in_i carries one height per request in raster order; the frame
// is column_count by row_count cells, set through the write port
// (cfg_we_i, cfg_idx_i, cfg_data_i), and any write to a known register
// restarts the frame. A cell lower than all four neighbours (border cells see
// height 9) adds its height plus one to the risk total and one to the count.
// Output channel out_o carries one request per frame with both saturated sums.
// Throughput: one cell per clock while in_i.ready is high. Each cell shifts a
// chain of line cells once, so the two stored rows cost nothing per item beyond
// that shift. The result passes the window column register, the judge stage
// and the accumulate into the queue after the frame's last cell is accepted.
// Results sit in a four-entry queue. While the receiver stalls, in_i.ready
// drops as soon as the queue plus frame ends still in the pipeline could fill
// it; nothing is lost. Reset sets 64 by 64 (column count clamped to
// MAX_COLUMNS), clears positions, sums and queue; the line cells are not
// cleared and are only read once written in the current frame.
module grid_local_minimum_scorer_unit import glms_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  glms_in_if.sink               in_i,
  glms_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W    = $clog2(MAX_COLUMNS);
  localparam int unsigned COLS_RST = (COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLS_RESET;
  localparam int unsigned PTR_W    = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W    = $clog2(RES_DEPTH + 1);

  logic [IDX_W-1:0] col_pos_q, col_pos_d;
  logic [ROW_W-1:0] row_pos_q, row_pos_d;
  logic [IDX_W-1:0] last_col_q, last_col_d;
  logic [IDX_W-1:0] entry_q, entry_d;
  logic [ROW_W-1:0] last_row_q, last_row_d;

  logic        in_fire;
  logic        cfg_restart;
  logic        at_last_col;
  logic        at_last_row;
  logic [31:0] cols_req;
  logic [ROW_W-1:0] rows_req;

  glms_line_t cell_data [MAX_COLUMNS];
  glms_line_t line_out;
  glms_line_t line_in;
  glms_col_t  col_d;

  logic       push;
  glms_res_t  push_res;
  logic [1:0] ends_in_flight;

  glms_res_t        res_mem [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             pop;
  logic [CNT_W:0]   room_need;

  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_restart = cfg_we_i && ((cfg_idx_i == CFG_COLUMN_COUNT) ||
                                    (cfg_idx_i == CFG_ROW_COUNT));
  assign at_last_col = (col_pos_q == last_col_q);
  assign at_last_row = (row_pos_q == last_row_q);

  // Line chain: fixed exit at the far end, entry point set by the column count
  assign line_out = cell_data[MAX_COLUMNS-1];
  assign line_in  = '{older: line_out.newer, newer: in_i.height};

  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
    if (i == 0) begin : g_head
      glms_line_cell #(
        .INDEX (i),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk_i   (clk_i),
        .shift_i (in_fire),
        .entry_i (entry_q),
        .fresh_i (line_in),
        .prev_i  (line_in),
        .data_o  (cell_data[i])
      );
    end else begin : g_body
      glms_line_cell #(
        .INDEX (i),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk_i   (clk_i),
        .shift_i (in_fire),
        .entry_i (entry_q),
        .fresh_i (line_in),
        .prev_i  (cell_data[i-1]),
        .data_o  (cell_data[i])
      );
    end
  end

  always_comb begin
    col_d.top      = line_out.older;
    col_d.mid      = line_out.newer;
    col_d.bot      = in_i.height;
    col_d.has_up   = (row_pos_q >= ROW_W'(2));
    col_d.has_mid  = (row_pos_q != '0);
    col_d.first    = (col_pos_q == '0);
    col_d.last_col = at_last_col;
    col_d.last_row = at_last_row;
  end

  // Configuration: clamp the counts once, at the write
  always_comb begin
    cols_req = {{(32-COL_CFG_W){1'b0}}, cfg_data_i[COL_CFG_W-1:0]};
    if (cols_req == 32'd0) begin
      cols_req = 32'd1;
    end else if (cols_req > 32'(MAX_COLUMNS)) begin
      cols_req = 32'(MAX_COLUMNS);
    end
    rows_req = cfg_data_i[ROW_W-1:0];

    last_col_d = last_col_q;
    entry_d    = entry_q;
    last_row_d = last_row_q;
    if (cfg_we_i && (cfg_idx_i == CFG_COLUMN_COUNT)) begin
      last_col_d = IDX_W'(cols_req - 32'd1);
      entry_d    = IDX_W'(32'(MAX_COLUMNS) - cols_req);
    end
    if (cfg_we_i && (cfg_idx_i == CFG_ROW_COUNT)) begin
      last_row_d = (rows_req == '0) ? '0 : (rows_req - ROW_W'(1));
    end
  end

  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    if (cfg_restart) begin
      col_pos_d = '0;
      row_pos_d = '0;
    end else if (in_fire) begin
      if (at_last_col && at_last_row) begin
        col_pos_d = '0;
        row_pos_d = '0;
      end else if (at_last_col) begin
        col_pos_d = '0;
        row_pos_d = row_pos_q + ROW_W'(1);
      end else begin
        col_pos_d = col_pos_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q  <= '0;
      row_pos_q  <= '0;
      last_col_q <= IDX_W'(COLS_RST - 1);
      entry_q    <= IDX_W'(MAX_COLUMNS - COLS_RST);
      last_row_q <= ROW_W'(ROWS_RESET - 1);
    end else begin
      col_pos_q  <= col_pos_d;
      row_pos_q  <= row_pos_d;
      last_col_q <= last_col_d;
      entry_q    <= entry_d;
      last_row_q <= last_row_d;
    end
  end

  glms_scorer u_scorer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .restart_i        (cfg_restart),
    .col_valid_i      (in_fire),
    .col_i            (col_d),
    .push_o           (push),
    .res_o            (push_res),
    .ends_in_flight_o (ends_in_flight)
  );

  // Result queue; hold the input while pending frame ends could overflow it
  assign pop         = out_o.valid && out_o.ready;
  assign room_need   = (CNT_W+1)'(count_q) + (CNT_W+1)'(ends_in_flight);
  assign in_i.ready  = (room_need < (CNT_W+1)'(RES_DEPTH));
  assign out_o.valid = (count_q != '0);
  assign out_o.total_risk    = res_mem[rd_ptr_q].total_risk;
  assign out_o.minimum_count = res_mem[rd_ptr_q].minimum_count;

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_mem[wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : (wr_ptr_q + PTR_W'(1));
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : (rd_ptr_q + PTR_W'(1));
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/glms_checker.sv
module glms_checker import glms_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [RISK_W-1:0]  total_risk_i,
  input logic [COUNT_W-1:0] minimum_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(total_risk_i) && $stable(minimum_count_i))
    else $error("result changed while stalled");

  // Every minimum adds at least one and at most sixteen
  a_risk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (total_risk_i >= RISK_W'(minimum_count_i)) &&
                    ((RISK_W+1)'(total_risk_i) <= {1'b0, minimum_count_i, 4'b0000}))
    else $error("risk total inconsistent with minima count");

  // A queue that fills from empty must follow an accepted input request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 3))
    else $error("result without a matching input request");

endmodule

bind grid_local_minimum_scorer_unit glms_checker u_glms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .total_risk_i    (out_o.total_risk),
  .minimum_count_i (out_o.minimum_count)
);

FILE: bench/tb.sv
module tb;
  import glms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CELLS   = 290;
  localparam int TALL_CELLS     = 48;

  localparam int unsigned LINE_IDX_W = $clog2(MAX_COLUMNS_DEFAULT);

  typedef enum logic {STEP_WRITE, STEP_CELL} step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [HEIGHT_W-1:0]   height;
    logic                  typed;
    glms_res_t             want;
  } step_t;

  localparam glms_res_t NO_SCORE = '0;
  localparam int DIRECTED_LEN = 41;

  localparam step_t DIRECTED_STEPS [DIRECTED_LEN] = '{
    // single cell frames: every cell meets the border on all four sides
    '{STEP_WRITE, CFG_COLUMN_COUNT, 16'hFE01, 4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_ROW_COUNT,    16'd1,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd0,  1'b1, '{28'd1, 24'd1}},
    '{STEP_CELL,  '0,               16'd0,    4'd9,  1'b1, '{28'd0, 24'd0}},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b1, '{28'd0, 24'd0}},
    '{STEP_CELL,  '0,               16'd0,    4'd8,  1'b1, '{28'd9, 24'd1}},
    // zero counts act as one, then two-cell frames in a row and in a column
    '{STEP_WRITE, CFG_COLUMN_COUNT, 16'd0,    4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_ROW_COUNT,    16'd0,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd3,  1'b1, '{28'd4, 24'd1}},
    '{STEP_WRITE, CFG_COLUMN_COUNT, 16'd2,    4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_ROW_COUNT,    16'd1,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd5,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd7,  1'b1, '{28'd6, 24'd1}},
    '{STEP_WRITE, CFG_COLUMN_COUNT, 16'd1,    4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_ROW_COUNT,    16'd2,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd9,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd2,  1'b1, '{28'd3, 24'd1}},
    // equal neighbours are not lower
    '{STEP_WRITE, CFG_COLUMN_COUNT, 16'd2,    4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_ROW_COUNT,    16'd2,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd1,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd1,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd1,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd0,  1'b1, '{28'd1, 24'd1}},
    // writes to unknown registers must not restart the frame
    '{STEP_WRITE, CFG_COLUMN_COUNT, 16'd3,    4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_ROW_COUNT,    16'd1,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd4,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_SPARE_A,      16'hFFFF, 4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_SPARE_B,      16'd0,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd2,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd6,  1'b1, '{28'd3, 24'd1}},
    // heights above nine still count when surrounded by higher ones
    '{STEP_WRITE, CFG_COLUMN_COUNT, 16'd3,    4'd0,  1'b0, NO_SCORE},
    '{STEP_WRITE, CFG_ROW_COUNT,    16'd3,    4'd0,  1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd10, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b0, NO_SCORE},
    '{STEP_CELL,  '0,               16'd0,    4'd15, 1'b1, '{28'd11, 24'd1}}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  glms_in_if  cell_if ();
  glms_out_if score_if ();

  grid_local_minimum_scorer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cell_if),
    .out_o      (score_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scorer state
  logic [HEIGHT_W-1:0]  older_row [MAX_COLUMNS_DEFAULT];
  logic [HEIGHT_W-1:0]  newer_row [MAX_COLUMNS_DEFAULT];
  logic [ROW_W-1:0]     row_pos;
  logic [COL_CFG_W-1:0] col_pos;
  logic [RISK_W-1:0]    risk_acc;
  logic [COUNT_W:0]     minima_acc;
  logic [COL_CFG_W-1:0] cols_cfg;
  logic [ROW_W-1:0]     rows_cfg;

  glms_res_t pending_scores [$];
  int        errors;
  int        send_calm;
  int        take_calm;
  bit        hold_off_request;

  function automatic void expect_score(input glms_res_t s);
    pending_scores.insert(pending_scores.size(), s);
  endfunction

  function automatic void restart_frame();
    row_pos    = '0;
    col_pos    = '0;
    risk_acc   = '0;
    minima_acc = '0;
  endfunction

  function automatic logic [COL_CFG_W-1:0] effective_cols();
    if (cols_cfg == '0) return COL_CFG_W'(1);
    if (cols_cfg > COL_CFG_W'(MAX_COLUMNS_DEFAULT)) return COL_CFG_W'(MAX_COLUMNS_DEFAULT);
    return cols_cfg;
  endfunction

  function automatic logic [ROW_W-1:0] effective_rows();
    return (rows_cfg == '0) ? ROW_W'(1) : rows_cfg;
  endfunction

  function automatic int frame_size();
    return int'(effective_cols()) * int'(effective_rows());
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_COLUMN_COUNT: begin
        cols_cfg = data[COL_CFG_W-1:0];
        restart_frame();
      end
      CFG_ROW_COUNT: begin
        rows_cfg = data[ROW_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic void judge_cell(input logic [HEIGHT_W-1:0] v, up, down, left, right);
    logic [RISK_W:0] sum;
    if (v < up && v < down && v < left && v < right) begin
      sum = (RISK_W+1)'(risk_acc) + (RISK_W+1)'(v) + (RISK_W+1)'(1);
      risk_acc = (sum > (RISK_W+1)'(RISK_LIMIT)) ? RISK_LIMIT : sum[RISK_W-1:0];
      if (minima_acc < (COUNT_W+1)'(COUNT_LIMIT))
        minima_acc = minima_acc + (COUNT_W+1)'(1);
    end
  endfunction

  // Judge every cell whose neighbours are now all known, then shift the line stores
  function automatic void score_cell(input logic [HEIGHT_W-1:0] h, output logic scored,
                                     output glms_res_t res);
    logic [COL_CFG_W-1:0]  cols;
    logic [COL_CFG_W-1:0]  c;
    logic [ROW_W-1:0]      rows;
    logic [ROW_W-1:0]      r;
    logic [LINE_IDX_W-1:0] at;
    logic                  last_row;
    logic                  last_col;
    cols = effective_cols();
    rows = effective_rows();
    if (col_pos >= cols) col_pos = '0;
    if (row_pos >= rows) row_pos = '0;
    c = col_pos;
    r = row_pos;
    at = c[LINE_IDX_W-1:0];
    last_row = (r == rows - ROW_W'(1));
    last_col = (c == cols - COL_CFG_W'(1));
    scored = 1'b0;
    res = '0;
    if (r >= 1)
      judge_cell(newer_row[at], (r >= 2) ? older_row[at] : BORDER_HEIGHT, h,
                 (c >= 1) ? older_row[at - LINE_IDX_W'(1)] : BORDER_HEIGHT,
                 last_col ? BORDER_HEIGHT : newer_row[at + LINE_IDX_W'(1)]);
    if (last_row && c >= 1)
      judge_cell(newer_row[at - LINE_IDX_W'(1)],
                 (r >= 1) ? older_row[at - LINE_IDX_W'(1)] : BORDER_HEIGHT,
                 BORDER_HEIGHT,
                 (c >= 2) ? newer_row[at - LINE_IDX_W'(2)] : BORDER_HEIGHT, h);
    if (last_row && last_col)
      judge_cell(h, (r >= 1) ? newer_row[at] : BORDER_HEIGHT, BORDER_HEIGHT,
                 (c >= 1) ? newer_row[at - LINE_IDX_W'(1)] : BORDER_HEIGHT, BORDER_HEIGHT);
    older_row[at] = newer_row[at];
    newer_row[at] = h;
    if (last_row && last_col) begin
      scored = 1'b1;
      res.total_risk = risk_acc;
      res.minimum_count = minima_acc[COUNT_W-1:0];
      restart_frame();
    end else if (last_col) begin
      col_pos = '0;
      row_pos = r + ROW_W'(1);
    end else begin
      col_pos = c + COL_CFG_W'(1);
    end
  endfunction

  function automatic logic [HEIGHT_W-1:0] draw_height();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return HEIGHT_W'($urandom_range(0, 9));
    if (roll < 17) return BORDER_HEIGHT;
    return HEIGHT_W'($urandom_range(10, 15));
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  task automatic draw_gap(inout int calm, output int gap);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (roll < 4) begin
      calm = $urandom_range(20, 80);
      gap = 0;
    end else if (roll < 55) begin
      gap = 0;
    end else if (roll < 85) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("tb: mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
    errors++;
  endtask

  task automatic send_cell(input logic [HEIGHT_W-1:0] h, input logic typed,
                           input glms_res_t want);
    int        gap;
    logic      scored;
    glms_res_t predicted;
    draw_gap(send_calm, gap);
    if (gap > 0) begin
      cell_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_if.valid  <= 1'b1;
    cell_if.height <= h;
    @(posedge clk_i);
    while (!cell_if.ready) @(posedge clk_i);
    score_cell(h, scored, predicted);
    if (typed) expect_score(want);
    else if (scored) expect_score(predicted);
  endtask

  // Write only once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cell_if.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_write(idx, data);
  endtask

  always @(posedge clk_i) begin
    glms_res_t want;
    if (rst_ni && score_if.valid && score_if.ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'(score_if.total_risk));
      end else begin
        want = pending_scores.pop_front();
        if (score_if.total_risk !== want.total_risk)
          report_mismatch("total_risk", 32'(want.total_risk), 32'(score_if.total_risk));
        if (score_if.minimum_count !== want.minimum_count)
          report_mismatch("minimum_count", 32'(want.minimum_count),
                          32'(score_if.minimum_count));
      end
    end
  end

  always @(posedge clk_i) begin
    int quiet_cycles;
    if (!rst_ni || (cell_if.valid && cell_if.ready) || (score_if.valid && score_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int wait_left;
    score_if.ready = 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        wait_left = LONG_HOLD;
      end else if (wait_left == 0 && score_if.valid && score_if.ready) begin
        draw_gap(take_calm, wait_left);
      end
      if (wait_left > 0) begin
        score_if.ready <= 1'b0;
        wait_left--;
      end else begin
        score_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int                    roll;
    int                    frames;
    int                    cells;
    int                    random_cells;
    logic [COL_CFG_W-1:0]  col_value;
    logic [CFG_DATA_W-1:0] col_data;
    logic [CFG_DATA_W-1:0] row_data;

    rst_ni         = 1'b0;
    cell_if.valid  = 1'b0;
    cell_if.height = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_COLUMN_COUNT;
    cfg_data_i     = '0;
    errors         = 0;
    send_calm      = 0;
    take_calm      = 0;
    random_cells   = 0;
    foreach (older_row[i]) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    cols_cfg = COL_CFG_W'(COLS_RESET);
    rows_cfg = ROW_W'(ROWS_RESET);
    restart_frame();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset column count, cut down to a single row
    write_reg(CFG_ROW_COUNT, 16'd1);
    repeat (frame_size()) send_cell(draw_height(), 1'b0, NO_SCORE);

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED_STEPS[i].kind == STEP_WRITE)
        write_reg(DIRECTED_STEPS[i].idx, DIRECTED_STEPS[i].data);
      else
        send_cell(DIRECTED_STEPS[i].height, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
    end

    // Hold the result side off while single cell frames keep coming
    write_reg(CFG_COLUMN_COUNT, 16'd1);
    write_reg(CFG_ROW_COUNT, 16'd1);
    hold_off_request = 1'b1;
    repeat (24) send_cell(draw_height(), 1'b0, NO_SCORE);

    // Tallest grid: run a few rows in, then abandon the frame
    write_reg(CFG_COLUMN_COUNT, 16'd16);
    write_reg(CFG_ROW_COUNT, 16'hFFFF);
    repeat (TALL_CELLS) send_cell(draw_height(), 1'b0, NO_SCORE);

    while (random_cells < RANDOM_CELLS) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) col_value = 9'd256;
      else if (roll == 1) col_value = COL_CFG_W'($urandom_range(257, 511));
      else if (roll == 2) col_value = '0;
      else if (roll < 7) col_value = COL_CFG_W'($urandom_range(9, 40));
      else col_value = COL_CFG_W'($urandom_range(1, 8));
      col_data = CFG_DATA_W'($urandom);
      col_data[COL_CFG_W-1:0] = col_value;

      // keep wide grids short
      if (roll < 2) row_data = CFG_DATA_W'($urandom_range(1, 2));
      else begin
        roll = $urandom_range(0, 19);
        if (roll == 0) row_data = '0;
        else if (roll < 4) row_data = CFG_DATA_W'($urandom_range(7, 16));
        else row_data = CFG_DATA_W'($urandom_range(1, 6));
      end

      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_COLUMN_COUNT, col_data);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(CFG_ROW_COUNT, row_data);
      end else begin
        write_reg(CFG_ROW_COUNT, row_data);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        write_reg(CFG_COLUMN_COUNT, col_data);
      end

      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        cells = frame_size();
        // now and then cut the last frame short; the next write restarts it
        if (f == frames - 1 && cells > 1 && $urandom_range(0, 7) == 0)
          cells = $urandom_range(1, cells - 1);
        // stop at the cell budget, leaving any frame unfinished
        if (cells > RANDOM_CELLS - random_cells)
          cells = RANDOM_CELLS - random_cells;
        repeat (cells) send_cell(draw_height(), 1'b0, NO_SCORE);
        random_cells += cells;
      end
    end

    cell_if.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
